// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define NTS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequence holds whenever the antecedent does
`define NTS_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/nts_pkg.sv =====
// shared constants and types for the nibble trie address set
package nts_pkg;

    localparam int CHILDREN = 16;
    localparam int LEVELS   = 8;
    localparam int NIB_W    = 4;
    localparam int USED_W   = 5;
    localparam int CNT_W    = 11;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_FIND   = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic child_we;
        logic info_we;
        logic stack_we;
    } nts_we_t;

endpackage

// ===== design/nts_store.sv =====
// child table, node info and free stack memories of the trie
module nts_store
    import nts_pkg::*;
#(
    parameter int NODE_POOL = 1024
)
(
    input  logic                                    clk,
    input  nts_we_t                                 we,
    input  logic [$clog2(NODE_POOL+1)+NIB_W-1:0]    child_wa,
    input  logic [$clog2(NODE_POOL+1)-1:0]          child_wd,
    input  logic [$clog2(NODE_POOL+1)+NIB_W-1:0]    child_ra,
    output logic [$clog2(NODE_POOL+1)-1:0]          child_q,
    input  logic [$clog2(NODE_POOL+1)-1:0]          info_wa,
    input  logic [$clog2(NODE_POOL+1)+USED_W+NIB_W:0] info_wd,
    input  logic [$clog2(NODE_POOL+1)-1:0]          info_ra,
    output logic [$clog2(NODE_POOL+1)+USED_W+NIB_W:0] info_q,
    input  logic [$clog2(NODE_POOL)-1:0]            stack_wa,
    input  logic [$clog2(NODE_POOL+1)-1:0]          stack_wd,
    input  logic [$clog2(NODE_POOL)-1:0]            stack_ra,
    output logic [$clog2(NODE_POOL+1)-1:0]          stack_q
);

    localparam int NW  = $clog2(NODE_POOL + 1);
    localparam int TOT = NODE_POOL + 1;
    localparam int IW  = NW + USED_W + NIB_W + 1;

    logic [NW-1:0] child_mem [TOT*CHILDREN];
    logic [IW-1:0] info_mem  [TOT];
    logic [NW-1:0] stack_mem [NODE_POOL];

    always_ff @(posedge clk)
    begin
        if (we.child_we)
        begin
            child_mem[child_wa] <= child_wd;
        end
        child_q <= child_mem[child_ra];
    end

    always_ff @(posedge clk)
    begin
        if (we.info_we)
        begin
            info_mem[info_wa] <= info_wd;
        end
        info_q <= info_mem[info_ra];
    end

    always_ff @(posedge clk)
    begin
        if (we.stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_q <= stack_mem[stack_ra];
    end

endmodule

// ===== design/nibble_trie_address_set.sv =====
// top level: sequencer that walks, grows and prunes the nibble trie
//
// channel   direction   signals
// command   in          start, mode, ip_key (busy is out)
// result    out         done, status, node_count, record_count
//
// after reset a clearing pass over all (NODE_POOL+1)*16 child table entries runs with busy high
// find walks each level through a read state and a check state, then checks the leaf record
// insert adds an allocate and a count update step for each node taken from the pool
// remove adds a free and a count decrement step for each node freed on the way back up
// the memories have registered reads, so each level needs a read state before its check
// each result beat shows for one cycle on done; the receiver cannot stall
module nibble_trie_address_set
    import nts_pkg::*;
#(
    parameter int NODE_POOL = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] ip_key,
    output logic        done,
    output logic [1:0]  status,
    output logic [10:0] node_count,
    output logic [10:0] record_count
);

`include "assert_macros.svh"

    localparam int NW  = $clog2(NODE_POOL + 1);
    localparam int SW  = $clog2(NODE_POOL);
    localparam int TOT = NODE_POOL + 1;
    localparam int CAW = NW + NIB_W;
    localparam int IW  = NW + USED_W + NIB_W + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_WRD   = 4'd2;
    localparam logic [3:0] S_WCHK  = 4'd3;
    localparam logic [3:0] S_ALLOC = 4'd4;
    localparam logic [3:0] S_INC   = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LCHK  = 4'd7;
    localparam logic [3:0] S_FREE  = 4'd8;
    localparam logic [3:0] S_FDEC  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [CAW-1:0]  clr_reg, clr_next;
    logic [1:0]      mode_reg, mode_next;
    logic [31:0]     key_reg, key_next;
    logic [2:0]      lv_reg, lv_next;
    logic [NW-1:0]   node_reg, node_next;
    logic [NW-1:0]   new_reg, new_next;
    logic [IW-1:0]   cinfo_reg, cinfo_next;
    logic [NW-1:0]   top_reg, top_next;
    logic [NW-1:0]   alloc_reg, alloc_next;
    logic [NW-1:0]   rec_reg, rec_next;
    logic [1:0]      st_reg, st_next;
    logic            done_reg;
    logic [1:0]      status_reg;
    logic [10:0]     node_count_reg, record_count_reg;

    nts_we_t         we;
    logic [CAW-1:0]  child_wa, child_ra;
    logic [NW-1:0]   child_wd, child_q;
    logic [NW-1:0]   info_wa, info_ra;
    logic [IW-1:0]   info_wd, info_q;
    logic [SW-1:0]   stack_wa, stack_ra;
    logic [NW-1:0]   stack_wd, stack_q;

    logic [NIB_W-1:0]  slot_cur;
    logic              last_lv;
    logic [USED_W-1:0] used_dec;
    logic [NW-1:0]     top_dec;
    logic [NW+10:0]    alloc_ext, rec_ext;

    assign slot_cur  = key_reg[{lv_reg, 2'b00} +: NIB_W];
    assign last_lv   = (lv_reg == 3'(LEVELS - 1));
    assign used_dec  = info_q[IW-2 -: USED_W] - USED_W'(1);
    assign top_dec   = top_reg - NW'(1);
    assign stack_ra  = top_dec[SW-1:0];
    assign alloc_ext = {11'd0, alloc_reg};
    assign rec_ext   = {11'd0, rec_reg};

    nts_store #(
        .NODE_POOL (NODE_POOL)
    ) u_store (
        .clk      (clk),
        .we       (we),
        .child_wa (child_wa),
        .child_wd (child_wd),
        .child_ra (child_ra),
        .child_q  (child_q),
        .info_wa  (info_wa),
        .info_wd  (info_wd),
        .info_ra  (info_ra),
        .info_q   (info_q),
        .stack_wa (stack_wa),
        .stack_wd (stack_wd),
        .stack_ra (stack_ra),
        .stack_q  (stack_q)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        lv_next    = lv_reg;
        node_next  = node_reg;
        new_next   = new_reg;
        cinfo_next = cinfo_reg;
        top_next   = top_reg;
        alloc_next = alloc_reg;
        rec_next   = rec_reg;
        st_next    = st_reg;
        we         = '0;
        child_wa   = {node_reg, slot_cur};
        child_wd   = '0;
        child_ra   = {node_reg, slot_cur};
        info_wa    = node_reg;
        info_wd    = info_q;
        info_ra    = node_reg;
        stack_wa   = top_reg[SW-1:0];
        stack_wd   = node_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    key_next   = ip_key;
                    lv_next    = '0;
                    node_next  = '0;
                    st_next    = ST_OK;
                    state_next = S_WRD;
                end
            end
            S_CLR:
            begin
                we.child_we = 1'b1;
                child_wa    = clr_reg;
                child_wd    = '0;
                if (clr_reg < CAW'(TOT))
                begin
                    we.info_we = 1'b1;
                    info_wa    = clr_reg[NW-1:0];
                    info_wd    = '0;
                end
                if (clr_reg < CAW'(NODE_POOL))
                begin
                    we.stack_we = 1'b1;
                    stack_wa    = clr_reg[SW-1:0];
                    stack_wd    = clr_reg[NW-1:0] + NW'(1);
                end
                clr_next = clr_reg + CAW'(1);
                if (clr_reg == CAW'(TOT * CHILDREN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRD:
            begin
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                if (child_q != '0)
                begin
                    node_next = child_q;
                    if (last_lv)
                    begin
                        state_next = S_LRD;
                    end
                    else
                    begin
                        lv_next    = lv_reg + 3'd1;
                        state_next = S_WRD;
                    end
                end
                else if (mode_reg == MODE_INSERT)
                begin
                    if (top_reg == '0)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cinfo_next = info_q;
                        state_next = S_ALLOC;
                    end
                end
                else
                begin
                    st_next    = ST_MISS;
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                we.child_we = 1'b1;
                child_wd    = stack_q;
                we.info_we  = 1'b1;
                info_wa     = stack_q;
                info_wd     = {1'b0, USED_W'(0), node_reg, slot_cur};
                new_next    = stack_q;
                top_next    = top_dec;
                alloc_next  = alloc_reg + NW'(1);
                state_next  = S_INC;
            end
            S_INC:
            begin
                we.info_we = 1'b1;
                info_wd    = cinfo_reg;
                info_wd[IW-2 -: USED_W] = cinfo_reg[IW-2 -: USED_W] + USED_W'(1);
                node_next  = new_reg;
                if (last_lv)
                begin
                    state_next = S_LRD;
                end
                else
                begin
                    lv_next    = lv_reg + 3'd1;
                    state_next = S_WRD;
                end
            end
            S_LRD:
            begin
                state_next = S_LCHK;
            end
            S_LCHK:
            begin
                state_next = S_DONE;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (info_q[IW-1])
                        begin
                            st_next = ST_DUP;
                        end
                        else
                        begin
                            we.info_we       = 1'b1;
                            info_wd[IW-1]    = 1'b1;
                            rec_next         = rec_reg + NW'(1);
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!info_q[IW-1])
                        begin
                            st_next = ST_MISS;
                        end
                        else
                        begin
                            we.info_we    = 1'b1;
                            info_wd[IW-1] = 1'b0;
                            rec_next      = rec_reg - NW'(1);
                            if ((info_q[IW-2 -: USED_W] == '0) && (node_reg != '0))
                            begin
                                cinfo_next = info_q;
                                state_next = S_FREE;
                            end
                        end
                    end
                    default:
                    begin
                        st_next = info_q[IW-1] ? ST_OK : ST_MISS;
                    end
                endcase
            end
            S_FREE:
            begin
                we.child_we = 1'b1;
                child_wa    = {cinfo_reg[NW+NIB_W-1:NIB_W], cinfo_reg[NIB_W-1:0]};
                child_wd    = '0;
                we.stack_we = 1'b1;
                info_ra     = cinfo_reg[NW+NIB_W-1:NIB_W];
                top_next    = top_reg + NW'(1);
                alloc_next  = alloc_reg - NW'(1);
                node_next   = cinfo_reg[NW+NIB_W-1:NIB_W];
                state_next  = S_FDEC;
            end
            S_FDEC:
            begin
                we.info_we = 1'b1;
                info_wd[IW-2 -: USED_W] = used_dec;
                if ((node_reg != '0) && (used_dec == '0))
                begin
                    cinfo_next = info_q;
                    cinfo_next[IW-2 -: USED_W] = used_dec;
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            top_reg   <= NW'(NODE_POOL);
            alloc_reg <= '0;
            rec_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            alloc_reg <= alloc_next;
            rec_reg   <= rec_next;
            done_reg  <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        lv_reg    <= lv_next;
        node_reg  <= node_next;
        new_reg   <= new_next;
        cinfo_reg <= cinfo_next;
        st_reg    <= st_next;
        if (state_reg == S_DONE)
        begin
            status_reg       <= st_reg;
            node_count_reg   <= alloc_ext[10:0];
            record_count_reg <= rec_ext[10:0];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign node_count   = node_count_reg;
    assign record_count = record_count_reg;

    `NTS_ASSERT(a_pool_balance, ({1'b0, top_reg} + {1'b0, alloc_reg}) == (NW+1)'(NODE_POOL))
    `NTS_ASSERT(a_records_le_nodes, rec_reg <= alloc_reg)
    `NTS_IMPLY(a_done_after_busy, done, $past(busy))

endmodule
